// ===== hw/rtl/vcd_pkg.sv =====
// shared types and constants for the voxel carving block
`default_nettype none

package vcd_pkg;

  localparam int NUM_VIEWS   = 6;
  localparam int SIZE_W      = 7;   // size registers, runs and distances
  localparam int COORD_W     = 6;   // map cell and voxel coordinates
  localparam int CELL_ADDR_W = 16;  // enough for the largest map, trimmed in the back end
  localparam int INDEX_W     = 18;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_reg_t;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [2:0] VIEW_PX = 3'd0;
  localparam logic [2:0] VIEW_NX = 3'd1;
  localparam logic [2:0] VIEW_PY = 3'd2;
  localparam logic [2:0] VIEW_NY = 3'd3;
  localparam logic [2:0] VIEW_PZ = 3'd4;
  localparam logic [2:0] VIEW_NZ = 3'd5;

  // one classified item on its way from the front end to the back end
  typedef struct packed {
    logic                                     is_query;
    logic [NUM_VIEWS-1:0]                     wr_views;
    logic [SIZE_W-1:0]                        run;
    logic [NUM_VIEWS-1:0][CELL_ADDR_W-1:0]    addr;
    logic [NUM_VIEWS-1:0][SIZE_W-1:0]         span;
    logic                                     in_grid;
    logic [INDEX_W-1:0]                       vidx;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vcd_front.sv =====
// front end: size registers, run scaling, map cell addresses and voxel index
`default_nettype none

module vcd_front #(
  parameter int MAX_DIM         = 64,
  parameter int DEPTH_FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [vcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vcd_pkg::SIZE_W-1:0]      cfg_data,
  input  wire logic                            in_kind,
  input  wire logic [2:0]                      in_view,
  input  wire logic [vcd_pkg::COORD_W-1:0]     in_map_col,
  input  wire logic [vcd_pkg::COORD_W-1:0]     in_map_row,
  input  wire logic [DEPTH_FRAC_BITS:0]        in_depth,
  input  wire logic [vcd_pkg::COORD_W-1:0]     in_voxel_x,
  input  wire logic [vcd_pkg::COORD_W-1:0]     in_voxel_y,
  input  wire logic [vcd_pkg::COORD_W-1:0]     in_voxel_z,
  output vcd_pkg::entry_t                      entry
);

  localparam int NV       = vcd_pkg::NUM_VIEWS;
  localparam int SW       = vcd_pkg::SIZE_W;
  localparam int AW       = vcd_pkg::CELL_ADDR_W;
  localparam int IW       = vcd_pkg::INDEX_W;
  localparam int NXY_W    = 2 * SW;
  localparam int ZP_W     = vcd_pkg::COORD_W + NXY_W;
  localparam int YP_W     = vcd_pkg::COORD_W + SW;
  localparam int PROD_W   = DEPTH_FRAC_BITS + 1 + SW;
  localparam int SIZE_RST = (MAX_DIM < 64) ? MAX_DIM : 64;

  logic [SW-1:0]    size_x_r, size_x_nxt;
  logic [SW-1:0]    size_y_r, size_y_nxt;
  logic [SW-1:0]    size_z_r, size_z_nxt;
  logic [NXY_W-1:0] nxy_r;

  function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v);
    if (v == '0) return SW'(1);
    else if (int'(v) > MAX_DIM) return SW'(MAX_DIM);
    else return v;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [SW-1:0] row,
                                              input logic [SW-1:0] col);
    return AW'(row) * AW'(MAX_DIM) + AW'(col);
  endfunction

  always_comb begin
    size_x_nxt = size_x_r;
    size_y_nxt = size_y_r;
    size_z_nxt = size_z_r;
    if (cfg_we) begin
      case (cfg_index)
        vcd_pkg::CFG_SIZE_X: size_x_nxt = clamp_size(cfg_data);
        vcd_pkg::CFG_SIZE_Y: size_y_nxt = clamp_size(cfg_data);
        vcd_pkg::CFG_SIZE_Z: size_z_nxt = clamp_size(cfg_data);
        default: ;
      endcase
    end
  end

  // plane size is built from the next register values so it lands with them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SW'(SIZE_RST);
      size_y_r <= SW'(SIZE_RST);
      size_z_r <= SW'(SIZE_RST);
      nxy_r    <= NXY_W'(SIZE_RST * SIZE_RST);
    end else begin
      size_x_r <= size_x_nxt;
      size_y_r <= size_y_nxt;
      size_z_r <= size_z_nxt;
      nxy_r    <= NXY_W'(size_x_nxt) * NXY_W'(size_y_nxt);
    end
  end

  // load path
  logic [SW-1:0]     n_sel;
  logic [PROD_W-1:0] prod;
  logic [SW:0]       run_raw;
  logic [SW-1:0]     run;
  logic              load_ok;
  logic [AW-1:0]     load_addr;

  always_comb begin
    case (in_view)
      vcd_pkg::VIEW_PX, vcd_pkg::VIEW_NX: n_sel = size_x_r;
      vcd_pkg::VIEW_PY, vcd_pkg::VIEW_NY: n_sel = size_y_r;
      default:                            n_sel = size_z_r;
    endcase
  end

  assign prod      = PROD_W'(in_depth) * PROD_W'(n_sel);
  assign run_raw   = prod[PROD_W-1:DEPTH_FRAC_BITS];
  assign run       = (run_raw > {1'b0, n_sel}) ? n_sel : run_raw[SW-1:0];
  assign load_ok   = (in_view < 3'(vcd_pkg::NUM_VIEWS)) &&
                     (int'(in_map_col) < MAX_DIM) && (int'(in_map_row) < MAX_DIM);
  assign load_addr = cell_addr(SW'(in_map_row), SW'(in_map_col));

  // query path
  logic [SW-1:0]   x7, y7, z7, mx, my, mz;
  logic            in_grid;
  logic [ZP_W-1:0] zp;
  logic [YP_W-1:0] yp;
  logic [IW-1:0]   vidx;

  assign x7 = SW'(in_voxel_x);
  assign y7 = SW'(in_voxel_y);
  assign z7 = SW'(in_voxel_z);
  // mirrored distances, only meaningful inside the grid
  assign mx = size_x_r - SW'(1) - x7;
  assign my = size_y_r - SW'(1) - y7;
  assign mz = size_z_r - SW'(1) - z7;
  assign in_grid = (x7 < size_x_r) && (y7 < size_y_r) && (z7 < size_z_r);

  assign zp   = ZP_W'(in_voxel_z) * ZP_W'(nxy_r);
  assign yp   = YP_W'(in_voxel_y) * YP_W'(size_x_r);
  assign vidx = IW'(zp) + IW'(yp) + IW'(in_voxel_x);

  always_comb begin
    entry          = '0;
    entry.is_query = (in_kind == vcd_pkg::KIND_QUERY);
    entry.run      = run;
    entry.in_grid  = in_grid;
    entry.vidx     = vidx;
    if (entry.is_query) begin
      entry.addr[0] = cell_addr(z7, y7);
      entry.addr[1] = cell_addr(mz, y7);
      entry.addr[2] = cell_addr(mz, x7);
      entry.addr[3] = cell_addr(z7, x7);
      entry.addr[4] = cell_addr(y7, x7);
      entry.addr[5] = cell_addr(my, x7);
      entry.span[0] = mx;
      entry.span[1] = x7;
      entry.span[2] = my;
      entry.span[3] = y7;
      entry.span[4] = mz;
      entry.span[5] = z7;
    end else begin
      for (int v = 0; v < vcd_pkg::NUM_VIEWS; v++) begin
        entry.addr[v] = load_addr;
      end
      if (load_ok) begin
        entry.wr_views = NV'(1) << in_view;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vcd_queue.sv =====
// short fifo of classified items between front end and back end
`default_nettype none

module vcd_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output      logic             push_ready,
  input  wire vcd_pkg::entry_t  push_data,
  output      logic             pop_valid,
  input  wire logic             pop_ready,
  output vcd_pkg::entry_t       pop_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  vcd_pkg::entry_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r < CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vcd_back.sv =====
// back end: six run memories, clearing sweep, carve test and result register
`default_nettype none

module vcd_back #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  output      logic                          q_ready,
  input  wire vcd_pkg::entry_t               q_entry,
  output      logic                          clearing,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          out_occupied,
  output      logic [vcd_pkg::INDEX_W-1:0]   out_voxel_index
);

  localparam int NV        = vcd_pkg::NUM_VIEWS;
  localparam int SW        = vcd_pkg::SIZE_W;
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  logic                        clearing_r, clearing_nxt;
  logic [ADDR_W-1:0]           clr_addr_r, clr_addr_nxt;
  logic                        pop, rd_en;
  logic [ADDR_W-1:0]           waddr;
  logic [SW-1:0]               wdata;
  logic [NV-1:0]               we;

  logic                        s2_valid_r, s2_valid_nxt;
  logic [NV-1:0][SW-1:0]       s2_dist_r;
  logic                        s2_in_grid_r;
  logic [vcd_pkg::INDEX_W-1:0] s2_vidx_r;
  logic                        s2_adv;
  logic [NV-1:0]               hit;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_occupied_r;
  logic [vcd_pkg::INDEX_W-1:0] out_voxel_index_r;

  // sweep every map cell to zero after reset
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign clearing = clearing_r;
  assign s2_adv   = s2_valid_r && (!out_valid_r || out_ready);
  assign q_ready  = !clearing_r && (!s2_valid_r || s2_adv);
  assign pop      = q_valid && q_ready;
  assign rd_en    = pop && q_entry.is_query;
  assign waddr    = clearing_r ? clr_addr_r : q_entry.addr[0][ADDR_W-1:0];
  assign wdata    = clearing_r ? '0 : q_entry.run;

  for (genvar v = 0; v < NV; v++) begin : g_view
    logic [SW-1:0] mem [MEM_DEPTH];
    logic [SW-1:0] rd_r;

    assign we[v] = clearing_r || (pop && q_entry.wr_views[v]);

    // read data holds while the compare stage is stalled
    always_ff @(posedge clk) begin
      if (we[v]) begin
        mem[waddr] <= wdata;
      end
      if (rd_en) begin
        rd_r <= mem[q_entry.addr[v][ADDR_W-1:0]];
      end
    end

    assign hit[v] = (rd_r > s2_dist_r[v]);
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (rd_en) s2_valid_nxt = 1'b1;
    else if (s2_adv) s2_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s2_dist_r    <= q_entry.span;
      s2_in_grid_r <= q_entry.in_grid;
      s2_vidx_r    <= q_entry.vidx;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_adv) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // outside the grid counts as empty space
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_occupied_r    <= s2_in_grid_r && !(|hit);
      out_voxel_index_r <= s2_vidx_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_occupied    = out_occupied_r;
  assign out_voxel_index = out_voxel_index_r;

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !pop)
    else $error("item taken from queue during clearing sweep");

  a_query_reaches_compare: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s2_valid_r)
    else $error("query read issued but compare stage empty");

  a_stalled_compare_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_adv) |=> (s2_valid_r && $stable(s2_dist_r) && $stable(s2_vidx_r)))
    else $error("stalled compare stage lost its item");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv |=> out_valid_r)
    else $error("result lost on the way to the output register");

endmodule

`default_nettype wire

// ===== hw/rtl/voxel_carve_by_depth_maps.sv =====
// top level of the voxel carving block
//
//   port group  dir   beat carries
//   cfg_*       in    size register write (index 0 x, 1 y, 2 z), no handshake
//   in_*        in    load of one depth sample or query of one voxel
//   out_*       out   occupancy and linear index, one beat per query
//
// one item per cycle sustained while out_ready stays high; a query result passes
// through the queue register, the registered run memory read and the output
// register. loads give no beat. after reset the block sweeps all
// MAX_DIM*MAX_DIM cells of the six run memories, one cell a cycle, with in_ready
// low. out_ready low stalls the compare stage, then the two-entry queue, then in_ready.
`default_nettype none

module voxel_carve_by_depth_maps #(
  parameter int MAX_DIM         = 64,
  parameter int DEPTH_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [vcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vcd_pkg::SIZE_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_kind,
  input  wire logic [2:0]                    in_view,
  input  wire logic [vcd_pkg::COORD_W-1:0]   in_map_col,
  input  wire logic [vcd_pkg::COORD_W-1:0]   in_map_row,
  input  wire logic [DEPTH_FRAC_BITS:0]      in_depth,
  input  wire logic [vcd_pkg::COORD_W-1:0]   in_voxel_x,
  input  wire logic [vcd_pkg::COORD_W-1:0]   in_voxel_y,
  input  wire logic [vcd_pkg::COORD_W-1:0]   in_voxel_z,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          out_occupied,
  output      logic [vcd_pkg::INDEX_W-1:0]   out_voxel_index
);

  vcd_pkg::entry_t front_entry;
  vcd_pkg::entry_t q_entry;
  logic            push_ready;
  logic            q_valid;
  logic            q_ready;
  logic            clearing;

  assign in_ready = push_ready && !clearing;

  vcd_front #(
    .MAX_DIM         (MAX_DIM),
    .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_kind    (in_kind),
    .in_view    (in_view),
    .in_map_col (in_map_col),
    .in_map_row (in_map_row),
    .in_depth   (in_depth),
    .in_voxel_x (in_voxel_x),
    .in_voxel_y (in_voxel_y),
    .in_voxel_z (in_voxel_z),
    .entry      (front_entry)
  );

  vcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid && !clearing),
    .push_ready (push_ready),
    .push_data  (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_entry)
  );

  vcd_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_entry         (q_entry),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_occupied    (out_occupied),
    .out_voxel_index (out_voxel_index)
  );

endmodule

`default_nettype wire

// ===== test/voxel_carve_by_depth_maps_test.sv =====
// testbench for the voxel carving block: directed and random loads and queries
`timescale 1ns / 100ps

module voxel_carve_by_depth_maps_test;

  localparam int FRAC_BITS    = 16;
  localparam int GRID_MAX     = 64;
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 125;
  localparam int NUM_PHASES   = 6;

  localparam logic [vcd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [2:0] VIEW_SPARE_A = 3'd6;
  localparam logic [2:0] VIEW_SPARE_B = 3'd7;
  localparam logic [FRAC_BITS:0] DEPTH_ONE = 17'h10000;
  localparam logic [FRAC_BITS:0] DEPTH_TOP = 17'h1FFFF;
  localparam logic [FRAC_BITS:0] CORNER_DEPTHS [4] = '{17'd0, 17'hFFFF, 17'h10000, 17'h1FFFF};

  // sizes per random phase; zero and 127 check the clamping
  localparam int PHASE_SIZES [NUM_PHASES][3] = '{
    '{4, 4, 4}, '{1, 1, 1}, '{8, 5, 64}, '{0, 127, 7}, '{3, 6, 2}, '{64, 64, 64}
  };
  localparam int SEND_IDLE [4] = '{0, 46, 0, 7};
  localparam int RECV_STALL [4] = '{0, 0, 46, 7};

  typedef struct packed {
    logic                          kind;
    logic [2:0]                    view;
    logic [vcd_pkg::COORD_W-1:0]   map_col;
    logic [vcd_pkg::COORD_W-1:0]   map_row;
    logic [FRAC_BITS:0]            depth;
    logic [vcd_pkg::COORD_W-1:0]   voxel_x;
    logic [vcd_pkg::COORD_W-1:0]   voxel_y;
    logic [vcd_pkg::COORD_W-1:0]   voxel_z;
  } item_t;

  typedef struct packed {
    logic                        occupied;
    logic [vcd_pkg::INDEX_W-1:0] voxel_index;
  } occ_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [vcd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vcd_pkg::SIZE_W-1:0]    cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_kind;
  logic [2:0]                    in_view;
  logic [vcd_pkg::COORD_W-1:0]   in_map_col;
  logic [vcd_pkg::COORD_W-1:0]   in_map_row;
  logic [FRAC_BITS:0]            in_depth;
  logic [vcd_pkg::COORD_W-1:0]   in_voxel_x;
  logic [vcd_pkg::COORD_W-1:0]   in_voxel_y;
  logic [vcd_pkg::COORD_W-1:0]   in_voxel_z;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_occupied;
  logic [vcd_pkg::INDEX_W-1:0]   out_voxel_index;

  // local copy of the block state
  logic [vcd_pkg::SIZE_W-1:0] carve_run [vcd_pkg::NUM_VIEWS][GRID_MAX][GRID_MAX];
  int unsigned grid_x, grid_y, grid_z;
  occ_t pending_occupancy[$];

  int send_idle_pct;
  int stall_pct;
  int quiet_cycles;
  int n_loads, n_queries, n_results, n_errors, n_settings;

  voxel_carve_by_depth_maps u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_view         (in_view),
    .in_map_col      (in_map_col),
    .in_map_row      (in_map_row),
    .in_depth        (in_depth),
    .in_voxel_x      (in_voxel_x),
    .in_voxel_y      (in_voxel_y),
    .in_voxel_z      (in_voxel_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_occupied    (out_occupied),
    .out_voxel_index (out_voxel_index)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned axis_len(logic [2:0] view);
    if (view < vcd_pkg::VIEW_PY) return grid_x;
    if (view < vcd_pkg::VIEW_PZ) return grid_y;
    return grid_z;
  endfunction

  function automatic logic run_reaches(logic [2:0] view, int unsigned col, int unsigned row,
                                       int unsigned span);
    return span < carve_run[view][row][col];
  endfunction

  // update the local state with one accepted beat and, for a query, queue its answer
  task automatic track_carving(input item_t it);
    int unsigned n, run, x, y, z;
    occ_t ans;
    if (it.kind == vcd_pkg::KIND_LOAD) begin
      n_loads++;
      if (it.view < vcd_pkg::NUM_VIEWS) begin
        n = axis_len(it.view);
        run = (int'(it.depth) * n) >> FRAC_BITS;
        if (run > n) run = n;
        carve_run[it.view][it.map_row][it.map_col] = vcd_pkg::SIZE_W'(run);
      end
    end else begin
      n_queries++;
      x = it.voxel_x;
      y = it.voxel_y;
      z = it.voxel_z;
      ans.voxel_index = vcd_pkg::INDEX_W'(z * grid_y * grid_x + y * grid_x + x);
      ans.occupied = 1'b0;
      // outside the box is empty space
      if (x < grid_x && y < grid_y && z < grid_z) begin
        ans.occupied = !(run_reaches(vcd_pkg::VIEW_PX, y, z, grid_x - 1 - x) ||
                         run_reaches(vcd_pkg::VIEW_NX, y, grid_z - 1 - z, x) ||
                         run_reaches(vcd_pkg::VIEW_PY, x, grid_z - 1 - z, grid_y - 1 - y) ||
                         run_reaches(vcd_pkg::VIEW_NY, x, z, y) ||
                         run_reaches(vcd_pkg::VIEW_PZ, x, y, grid_z - 1 - z) ||
                         run_reaches(vcd_pkg::VIEW_NZ, x, grid_y - 1 - y, z));
      end
      pending_occupancy.push_back(ans);
    end
  endtask

  function automatic item_t random_item();
    item_t it;
    int unsigned col_lim, row_lim;
    it.kind = ($urandom_range(0, 1) == 0) ? vcd_pkg::KIND_LOAD : vcd_pkg::KIND_QUERY;
    it.view = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    col_lim = (it.view < vcd_pkg::VIEW_PY) ? grid_y : grid_x;
    row_lim = (it.view < vcd_pkg::VIEW_PZ) ? grid_z : grid_y;
    it.map_col = ($urandom_range(0, 4) == 0) ? vcd_pkg::COORD_W'($urandom)
                 : vcd_pkg::COORD_W'($urandom_range(0, col_lim - 1));
    it.map_row = ($urandom_range(0, 4) == 0) ? vcd_pkg::COORD_W'($urandom)
                 : vcd_pkg::COORD_W'($urandom_range(0, row_lim - 1));
    case ($urandom_range(0, 3))
      0: it.depth = 17'($urandom);
      1: it.depth = CORNER_DEPTHS[$urandom_range(0, 3)];
      default: it.depth = 17'($urandom_range(0, DEPTH_ONE));
    endcase
    if ($urandom_range(0, 6) == 0) begin
      it.voxel_x = vcd_pkg::COORD_W'($urandom);
      it.voxel_y = vcd_pkg::COORD_W'($urandom);
      it.voxel_z = vcd_pkg::COORD_W'($urandom);
    end else begin
      it.voxel_x = vcd_pkg::COORD_W'($urandom_range(0, grid_x - 1));
      it.voxel_y = vcd_pkg::COORD_W'($urandom_range(0, grid_y - 1));
      it.voxel_z = vcd_pkg::COORD_W'($urandom_range(0, grid_z - 1));
    end
    return it;
  endfunction

  function automatic item_t load_item(logic [2:0] view, logic [vcd_pkg::COORD_W-1:0] col,
                                      logic [vcd_pkg::COORD_W-1:0] row,
                                      logic [FRAC_BITS:0] depth);
    item_t it;
    it = random_item();
    it.kind = vcd_pkg::KIND_LOAD;
    it.view = view;
    it.map_col = col;
    it.map_row = row;
    it.depth = depth;
    return it;
  endfunction

  function automatic item_t query_item(logic [vcd_pkg::COORD_W-1:0] x,
                                       logic [vcd_pkg::COORD_W-1:0] y,
                                       logic [vcd_pkg::COORD_W-1:0] z);
    item_t it;
    it = random_item();
    it.kind = vcd_pkg::KIND_QUERY;
    it.voxel_x = x;
    it.voxel_y = y;
    it.voxel_z = z;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_kind    = it.kind;
    in_view    = it.view;
    in_map_col = it.map_col;
    in_map_row = it.map_row;
    in_depth   = it.depth;
    in_voxel_x = it.voxel_x;
    in_voxel_y = it.voxel_y;
    in_voxel_z = it.voxel_z;
    do @(posedge clk); while (in_ready !== 1'b1);
    track_carving(it);
    @(negedge clk);
  endtask

  // loads give no beat, so allow the pipe to empty after the last answer
  task automatic settle();
    in_valid = 1'b0;
    while (pending_occupancy.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [vcd_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    int unsigned fitted;
    fitted = value & 32'h7F;
    if (fitted == 0) fitted = 1;
    if (fitted > GRID_MAX) fitted = GRID_MAX;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = vcd_pkg::SIZE_W'(value);
    case (idx)
      vcd_pkg::CFG_SIZE_X: grid_x = fitted;
      vcd_pkg::CFG_SIZE_Y: grid_y = fitted;
      vcd_pkg::CFG_SIZE_Z: grid_z = fitted;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  // default 64 cube: empty maps, ignored views, one carve per view
  task automatic test_power_on_views();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(query_item(6'd0, 6'd0, 6'd0));
    send_item(query_item(6'd63, 6'd63, 6'd63));
    send_item(load_item(VIEW_SPARE_A, 6'd0, 6'd0, DEPTH_TOP));
    send_item(load_item(VIEW_SPARE_B, 6'd0, 6'd0, DEPTH_TOP));
    send_item(query_item(6'd0, 6'd0, 6'd0));
    send_item(load_item(vcd_pkg::VIEW_PX, 6'd5, 6'd7, DEPTH_ONE));
    send_item(query_item(6'd0, 6'd5, 6'd7));
    send_item(load_item(vcd_pkg::VIEW_NX, 6'd9, 6'd60, 17'd1));
    send_item(query_item(6'd0, 6'd9, 6'd3));
    send_item(load_item(vcd_pkg::VIEW_PY, 6'd10, 6'd20, 17'h8000));
    send_item(query_item(6'd10, 6'd32, 6'd43));
    send_item(query_item(6'd10, 6'd31, 6'd43));
    send_item(load_item(vcd_pkg::VIEW_NY, 6'd63, 6'd0, DEPTH_TOP));
    send_item(query_item(6'd63, 6'd63, 6'd0));
    send_item(load_item(vcd_pkg::VIEW_PZ, 6'd0, 6'd63, 17'd1024));
    send_item(query_item(6'd0, 6'd63, 6'd63));
    send_item(load_item(vcd_pkg::VIEW_NZ, 6'd33, 6'd44, 17'hFFFF));
    send_item(query_item(6'd33, 6'd19, 6'd63));
    send_item(query_item(6'd33, 6'd19, 6'd62));
    settle();
  endtask

  // clamped sizes, spare index, voxels outside the box, cells beyond the grid
  task automatic test_size_limits();
    write_reg(vcd_pkg::CFG_SIZE_X, 0);
    write_reg(vcd_pkg::CFG_SIZE_Y, 127);
    write_reg(vcd_pkg::CFG_SIZE_Z, 65);
    write_reg(CFG_SPARE, 5);
    n_settings++;
    send_item(query_item(6'd0, 6'd5, 6'd7));
    send_item(query_item(6'd1, 6'd0, 6'd0));
    send_item(query_item(6'd63, 6'd63, 6'd63));
    settle();
    write_reg(vcd_pkg::CFG_SIZE_Y, 8);
    send_item(load_item(vcd_pkg::VIEW_PY, 6'd30, 6'd10, DEPTH_ONE));
    send_item(query_item(6'd0, 6'd7, 6'd53));
    settle();
    // the cell beyond x only becomes visible once the grid grows
    write_reg(vcd_pkg::CFG_SIZE_X, 64);
    n_settings++;
    send_item(query_item(6'd30, 6'd7, 6'd53));
    settle();
    write_reg(vcd_pkg::CFG_SIZE_Y, 64);
    send_item(query_item(6'd63, 6'd63, 6'd63));
    settle();
    write_reg(vcd_pkg::CFG_SIZE_Z, 1);
    n_settings++;
    send_item(load_item(vcd_pkg::VIEW_PZ, 6'd2, 6'd3, DEPTH_ONE));
    send_item(query_item(6'd2, 6'd3, 6'd0));
    send_item(query_item(6'd2, 6'd3, 6'd1));
    settle();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(vcd_pkg::CFG_SIZE_X, PHASE_SIZES[p][0]);
      write_reg(vcd_pkg::CFG_SIZE_Y, PHASE_SIZES[p][1]);
      write_reg(vcd_pkg::CFG_SIZE_Z, PHASE_SIZES[p][2]);
      n_settings++;
      send_idle_pct = SEND_IDLE[p % 4];
      stall_pct = RECV_STALL[p % 4];
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
      settle();
    end
  endtask

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    occ_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      n_results++;
      if (pending_occupancy.size() == 0) begin
        report_mismatch("unexpected result beat, voxel_index", out_voxel_index, -1);
      end else begin
        want = pending_occupancy.pop_front();
        if (out_occupied !== want.occupied)
          report_mismatch("occupied", out_occupied, want.occupied);
        if (out_voxel_index !== want.voxel_index)
          report_mismatch("voxel_index", out_voxel_index, want.voxel_index);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d answers outstanding",
               quiet_cycles, pending_occupancy.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = vcd_pkg::CFG_SIZE_X;
    cfg_data = '0;
    in_valid = 1'b0;
    in_kind = vcd_pkg::KIND_LOAD;
    in_view = vcd_pkg::VIEW_PX;
    in_map_col = '0;
    in_map_row = '0;
    in_depth = '0;
    in_voxel_x = '0;
    in_voxel_y = '0;
    in_voxel_z = '0;
    out_ready = 1'b1;
    send_idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    n_loads = 0;
    n_queries = 0;
    n_results = 0;
    n_errors = 0;
    n_settings = 1;
    grid_x = GRID_MAX;
    grid_y = GRID_MAX;
    grid_z = GRID_MAX;
    for (int v = 0; v < vcd_pkg::NUM_VIEWS; v++)
      for (int r = 0; r < GRID_MAX; r++)
        for (int c = 0; c < GRID_MAX; c++)
          carve_run[v][r][c] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_power_on_views();
    test_size_limits();
    test_random_traffic();
    settle();

    $display("covered %0d loads and %0d queries over %0d grid settings and four idle patterns",
             n_loads, n_queries, n_settings);
    $display("checked %0d result beats, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
